### hdl/max_square_of_ones_macros.svh
// Assertion macros for the max_square_of_ones checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef MAX_SQUARE_OF_ONES_MACROS_SVH
`define MAX_SQUARE_OF_ONES_MACROS_SVH

// same-cycle implication
`define MSQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/msq_pkg.sv
// Shared types and constants for max_square_of_ones.
// No dependencies.
`timescale 1ns / 1ps

package msq_pkg;

    localparam int SIZE_W             = 11;
    localparam int MAX_COLUMNS_DEF    = 1024;
    localparam logic [SIZE_W-1:0] ROW_WIDTH_RESET = 11'd1024;
    localparam logic [SIZE_W-1:0] SIZE_SAT        = '1;

    typedef logic [SIZE_W-1:0] size_t;

    // request travelling down the cell chain
    typedef struct packed {
        logic  cell_bit;
        logic  first;
        logic  last;
        size_t size;
    } tok_t;

endpackage

### hdl/msq_cell.sv
// One column cell: holds the latest and previous square size of its column.
// Depends on msq_pkg.
`timescale 1ns / 1ps

module msq_cell
    import msq_pkg::*;
#(
    parameter int COL_W = 10,
    parameter int IDX   = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             vld_in,
    input  tok_t             tok_in,
    input  logic [COL_W-1:0] col_in,
    input  size_t            left_val,
    input  size_t            left_old,
    output logic             vld_out,
    output tok_t             tok_out,
    output logic [COL_W-1:0] col_out,
    output size_t            val_out,
    output size_t            old_out
);

    logic             vld_reg;
    tok_t             tok_reg;
    logic [COL_W-1:0] col_reg;
    size_t            val_reg;
    size_t            old_reg;
    logic             hit;
    size_t            upper;
    size_t            upper_left;
    size_t            min_lu;
    size_t            min_all;
    size_t            size_next;

    assign hit = vld_reg && (col_reg == COL_W'(IDX));

    always_comb
    begin
        upper      = tok_reg.first ? '0 : val_reg;
        upper_left = tok_reg.first ? '0 : left_old;
        min_lu     = (left_val < upper) ? left_val : upper;
        min_all    = (min_lu < upper_left) ? min_lu : upper_left;
        if (!tok_reg.cell_bit)
        begin
            size_next = '0;
        end
        else if (min_all == SIZE_SAT)
        begin
            size_next = SIZE_SAT;
        end
        else
        begin
            size_next = min_all + 1'b1;
        end
    end

    always_comb
    begin
        tok_out = tok_reg;
        if (hit)
        begin
            tok_out.size = size_next;
        end
    end

    assign vld_out = vld_reg;
    assign col_out = col_reg;
    assign val_out = val_reg;
    assign old_out = old_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg <= tok_in;
            col_reg <= col_in;
            if (hit)
            begin
                val_reg <= size_next;
                old_reg <= val_reg;
            end
        end
    end

endmodule

### hdl/msq_front.sv
// Input side: row width register, column counter and first-row flag.
// Depends on msq_pkg; feeds the first cell of the chain.
`timescale 1ns / 1ps

module msq_front
    import msq_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int COL_W       = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  size_t            row_width,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic             cell_bit,
    input  logic             last_cell,
    input  logic             adv,
    output logic             vld_out,
    output tok_t             tok_out,
    output logic [COL_W-1:0] col_out
);

    localparam int CMP_W = ($clog2(MAX_COLUMNS + 1) > SIZE_W) ?
                           $clog2(MAX_COLUMNS + 1) : SIZE_W;

    size_t            row_width_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             first_reg;
    logic             first_next;
    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] width_eff;
    logic [CMP_W-1:0] col_inc;
    logic             wrap;
    logic             accept;

    assign cfg_ready  = 1'b1;
    assign item_stall = !adv;
    assign accept     = item_valid && adv;

    always_comb
    begin
        width_ext = CMP_W'(row_width_reg);
        if (width_ext == '0)
        begin
            width_eff = CMP_W'(1);
        end
        else if (width_ext > CMP_W'(MAX_COLUMNS))
        begin
            width_eff = CMP_W'(MAX_COLUMNS);
        end
        else
        begin
            width_eff = width_ext;
        end
        col_inc = CMP_W'(col_reg) + CMP_W'(1);
        wrap    = (col_inc >= width_eff);
    end

    always_comb
    begin
        if (last_cell)
        begin
            col_next   = '0;
            first_next = 1'b1;
        end
        else if (wrap)
        begin
            col_next   = '0;
            first_next = 1'b0;
        end
        else
        begin
            col_next   = col_inc[COL_W-1:0];
            first_next = first_reg;
        end
    end

    always_comb
    begin
        vld_out          = accept;
        tok_out.cell_bit = cell_bit;
        tok_out.first    = first_reg;
        tok_out.last     = last_cell;
        tok_out.size     = '0;
        col_out          = col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            col_reg       <= '0;
            first_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                row_width_reg <= row_width;
            end
            if (accept)
            begin
                col_reg   <= col_next;
                first_reg <= first_next;
            end
        end
    end

endmodule

### hdl/msq_tail.sv
// Output side: running maximum and result register at the end of the chain.
// Depends on msq_pkg; also produces the chain advance enable.
`timescale 1ns / 1ps

module msq_tail
    import msq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  vld_in,
    input  tok_t  tok_in,
    output logic  adv,
    output logic  result_valid,
    input  logic  result_stall,
    output size_t max_side
);

    size_t best_reg;
    size_t best_next;
    logic  result_valid_reg;
    size_t max_side_reg;
    logic  take;

    assign adv       = !(vld_in && tok_in.last && result_valid_reg && result_stall);
    assign take      = adv && vld_in;
    assign best_next = (tok_in.size > best_reg) ? tok_in.size : best_reg;

    assign result_valid = result_valid_reg;
    assign max_side     = max_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                best_reg <= tok_in.last ? '0 : best_next;
            end
            if (take && tok_in.last)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && tok_in.last)
        begin
            max_side_reg <= best_next;
        end
    end

endmodule

### hdl/max_square_of_ones.sv
// Top level of max_square_of_ones: front, chain of column cells, tail.
// Depends on msq_pkg, msq_front, msq_cell, msq_tail.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------
//  item     | item_valid, item_stall | cell_bit, last_cell
//  result   | result_valid, result_stall | max_side
//  cfg      | cfg_valid, cfg_ready   | row_width
//
// One cell per cycle while item_stall is low. A request walks one cell per
// cycle down MAX_COLUMNS column cells while the chain advances and is sized
// in the cell of its column; the tail registers the result on the last cell.
// Reset clears the column counter, running maximum and chain valid bits;
// cell contents are not cleared. A held result with another end of matrix
// at the tail freezes the whole chain and stalls the input.
`timescale 1ns / 1ps

module max_square_of_ones
    import msq_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_valid,
    output logic  cfg_ready,
    input  size_t row_width,
    input  logic  item_valid,
    output logic  item_stall,
    input  logic  cell_bit,
    input  logic  last_cell,
    output logic  result_valid,
    input  logic  result_stall,
    output size_t max_side
);

    localparam int COL_W = $clog2(MAX_COLUMNS);

    logic             adv;
    logic             vld_chain [0:MAX_COLUMNS];
    tok_t             tok_chain [0:MAX_COLUMNS];
    logic [COL_W-1:0] col_chain [0:MAX_COLUMNS];
    size_t            val_arr   [0:MAX_COLUMNS-1];
    size_t            old_arr   [0:MAX_COLUMNS-1];

    msq_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .COL_W       (COL_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .row_width  (row_width),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cell_bit   (cell_bit),
        .last_cell  (last_cell),
        .adv        (adv),
        .vld_out    (vld_chain[0]),
        .tok_out    (tok_chain[0]),
        .col_out    (col_chain[0])
    );

    for (genvar i = 0; i < MAX_COLUMNS; i++)
    begin : g_cell
        size_t left_val;
        size_t left_old;

        if (i == 0)
        begin : g_edge
            assign left_val = '0;
            assign left_old = '0;
        end
        else
        begin : g_inner
            assign left_val = val_arr[i-1];
            assign left_old = old_arr[i-1];
        end

        msq_cell #(
            .COL_W (COL_W),
            .IDX   (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .vld_in   (vld_chain[i]),
            .tok_in   (tok_chain[i]),
            .col_in   (col_chain[i]),
            .left_val (left_val),
            .left_old (left_old),
            .vld_out  (vld_chain[i+1]),
            .tok_out  (tok_chain[i+1]),
            .col_out  (col_chain[i+1]),
            .val_out  (val_arr[i]),
            .old_out  (old_arr[i])
        );
    end

    msq_tail u_tail (
        .clk          (clk),
        .rst_n        (rst_n),
        .vld_in       (vld_chain[MAX_COLUMNS]),
        .tok_in       (tok_chain[MAX_COLUMNS]),
        .adv          (adv),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .max_side     (max_side)
    );

endmodule

### hdl/msq_checker.sv
// Port-level checks for max_square_of_ones, bound to the top level.
// Depends on msq_pkg and max_square_of_ones_macros.svh.
`timescale 1ns / 1ps
`include "max_square_of_ones_macros.svh"

module msq_checker
    import msq_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input logic  clk,
    input logic  rst_n,
    input logic  cfg_valid,
    input logic  cfg_ready,
    input size_t row_width,
    input logic  item_valid,
    input logic  item_stall,
    input logic  cell_bit,
    input logic  last_cell,
    input logic  result_valid,
    input logic  result_stall,
    input size_t max_side
);

    // input only backs up behind a blocked result
    `MSQ_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall, "input stalled without blocked result")

    // a square never exceeds the column limit
    `MSQ_ASSERT_NOW(a_side_range, result_valid, max_side <= MAX_COLUMNS, "max_side out of range")

    `MSQ_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(max_side), "stalled result changed")

endmodule

bind max_square_of_ones msq_checker #(.MAX_COLUMNS(MAX_COLUMNS)) u_msq_checker (.*);

### tb/max_square_of_ones_test.sv
// Testbench for max_square_of_ones: streams binary matrices, predicts the largest square.
// Self-checking against an in-bench predictor; depends on msq_pkg and max_square_of_ones.
`timescale 1ns / 1ps

module max_square_of_ones_test;
    import msq_pkg::*;

    localparam int COLS         = MAX_COLUMNS_DEF;
    localparam int SETTLE       = COLS + 64;
    localparam int LONG_HOLD    = 3000;
    localparam int QUIET_LIMIT  = 20000;
    localparam int RANDOM_CELLS = 500;
    localparam int MIN_RESULTS  = 40;

    typedef struct packed {
        logic is_one;
        logic is_last;
    } cell_req_t;

    logic  clk;
    logic  rst_n        = 1'b0;
    logic  cfg_valid    = 1'b0;
    logic  cfg_ready;
    size_t row_width    = ROW_WIDTH_RESET;
    logic  item_valid   = 1'b0;
    logic  item_stall;
    logic  cell_bit     = 1'b0;
    logic  last_cell    = 1'b0;
    logic  result_valid;
    logic  result_stall = 1'b0;
    size_t max_side;

    cell_req_t cell_q[$];
    cell_req_t next_req;
    size_t     pending_max_sides[$];

    // predictor state
    size_t line_sizes[COLS];
    size_t left_run    = '0;
    size_t diag_run    = '0;
    size_t best_run    = '0;
    size_t width_reg   = ROW_WIDTH_RESET;
    int    scan_col    = 0;
    bit    on_top_row  = 1'b1;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int gap_left;
    int hold_left;
    logic hold_token = 1'b0;
    logic hold_seen;
    int quiet_cycles;

    int mismatches      = 0;
    int cells_sent      = 0;
    int results_checked = 0;
    int width_writes    = 0;
    int in_stall_cycles = 0;

    max_square_of_ones DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .row_width    (row_width),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cell_bit     (cell_bit),
        .last_cell    (last_cell),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .max_side     (max_side)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int effective_width(input size_t w);
        if (w == 0)
            return 1;
        if (w > COLS)
            return COLS;
        return int'(w);
    endfunction

    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 60);
        return $urandom_range(1, 3);
    endfunction

    // square size of one cell; on the last cell, queue the running maximum
    task automatic track_square(input logic one, input logic is_last);
        int    c;
        size_t from_left, from_up, from_diag, m, sz;
        c = scan_col;
        from_left = (c == 0) ? '0 : left_run;
        from_up   = on_top_row ? '0 : line_sizes[c];
        from_diag = (on_top_row || c == 0) ? '0 : diag_run;
        m = (from_left < from_up) ? from_left : from_up;
        m = (m < from_diag) ? m : from_diag;
        if (!one)
            sz = '0;
        else if (m == SIZE_SAT)
            sz = SIZE_SAT;
        else
            sz = m + 1'b1;
        line_sizes[c] = sz;
        if (sz > best_run)
            best_run = sz;
        if (c + 1 >= effective_width(width_reg))
        begin
            scan_col   = 0;
            left_run   = '0;
            diag_run   = '0;
            on_top_row = 1'b0;
        end
        else
        begin
            scan_col = c + 1;
            left_run = sz;
            diag_run = from_up;
        end
        if (is_last)
        begin
            pending_max_sides.insert(pending_max_sides.size(), best_run);
            scan_col   = 0;
            left_run   = '0;
            diag_run   = '0;
            on_top_row = 1'b1;
            best_run   = '0;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            cell_bit   <= 1'b0;
            last_cell  <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                track_square(cell_bit, last_cell);
                cells_sent++;
            end
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (cell_q.size() != 0)
                begin
                    next_req = cell_q.pop_front();
                    item_valid <= 1'b1;
                    cell_bit   <= next_req.is_one;
                    last_cell  <= next_req.is_last;
                    gap_left = pick_gap(tx_idle_pct);
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left = 0;
            hold_seen = 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_max_sides.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got max_side %0d",
                             $time, max_side);
                    mismatches++;
                end
                else
                begin
                    if (max_side !== pending_max_sides[0])
                    begin
                        $display("%0t: max_side mismatch, expected %0d, got %0d",
                                 $time, pending_max_sides[0], max_side);
                        mismatches++;
                    end
                    void'(pending_max_sides.pop_front());
                    results_checked++;
                end
            end
            if (hold_seen != hold_token)
            begin
                hold_seen = hold_token;
                hold_left = LONG_HOLD;
            end
            if (hold_left == 0)
                hold_left = pick_gap(rx_idle_pct);
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            if (item_valid && item_stall)
                in_stall_cycles++;
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: no request accepted for %0d cycles", $time, quiet_cycles);
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    task automatic queue_cell(input logic one, input logic is_last);
        cell_req_t req;
        req.is_one  = one;
        req.is_last = is_last;
        cell_q.insert(cell_q.size(), req);
    endtask

    // matrix of n_cells in rows of cols, random fill plus an optional planted square
    task automatic queue_matrix(input int cols, input int n_cells, input int ones_pct,
                                input int plant);
        int   rows, r0, c0, r, c;
        logic one;
        rows = (n_cells + cols - 1) / cols;
        r0 = (plant > 0 && rows > plant) ? $urandom_range(0, rows - plant) : 0;
        c0 = (plant > 0 && cols > plant) ? $urandom_range(0, cols - plant) : 0;
        for (int i = 0; i < n_cells; i++)
        begin
            r = i / cols;
            c = i % cols;
            one = ($urandom_range(1, 100) <= ones_pct) ||
                  (plant > 0 && r >= r0 && r < r0 + plant && c >= c0 && c < c0 + plant);
            queue_cell(one, i == n_cells - 1);
        end
    endtask

    task automatic drain();
        while (cell_q.size() != 0 || item_valid || pending_max_sides.size() != 0)
            @(negedge clk);
    endtask

    // cells without a result may still be in the chain: let it empty before the write
    task automatic set_width(input size_t w);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        row_width <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        width_reg = w;
        width_writes++;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int    eff, rows, n, side, random_cells;
        size_t w;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-cell matrices at the reset width
        queue_cell(1'b0, 1'b1);
        queue_cell(1'b1, 1'b1);
        // zero width acts as one column
        set_width(11'd0);
        queue_cell(1'b1, 1'b0);
        queue_cell(1'b1, 1'b0);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b1, 1'b1);
        set_width(11'd3);
        repeat (5) queue_cell(1'b1, 1'b0);
        queue_cell(1'b1, 1'b1);
        // width shrunk mid-row ends the row at once
        set_width(11'd4);
        repeat (6) queue_cell(1'b1, 1'b0);
        set_width(11'd2);
        queue_cell(1'b1, 1'b0);
        queue_cell(1'b1, 1'b0);
        queue_cell(1'b1, 1'b1);
        // width widened mid-matrix
        queue_cell(1'b1, 1'b0);
        queue_cell(1'b1, 1'b0);
        queue_cell(1'b1, 1'b0);
        set_width(11'd4);
        queue_cell(1'b1, 1'b0);
        queue_cell(1'b0, 1'b0);
        queue_cell(1'b1, 1'b1);

        // oversized width acts as the full line, two rows deep
        set_width(11'd2047);
        tx_idle_pct = 20;
        rx_idle_pct = 10;
        queue_matrix(COLS, COLS + 3, 95, 2);

        // long receiver hold while the sender keeps offering
        set_width(11'd4);
        tx_idle_pct = 100;
        rx_idle_pct = 0;
        @(posedge clk);
        hold_token <= ~hold_token;
        repeat (40) queue_matrix(4, $urandom_range(4, 12), 80, 2);

        random_cells = 0;
        while (random_cells < RANDOM_CELLS || results_checked < MIN_RESULTS)
        begin
            case ($urandom_range(0, 19))
                0:       w = 11'd0;
                1:       w = 11'd2047;
                2:       w = 11'd1024;
                3, 4, 5: w = size_t'($urandom_range(17, 48));
                default: w = size_t'($urandom_range(1, 16));
            endcase
            set_width(w);
            eff = effective_width(w);
            case ($urandom_range(0, 2))
                0:       tx_idle_pct = 0;
                1:       tx_idle_pct = 20;
                default: tx_idle_pct = 60;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_idle_pct = 0;
                1:       rx_idle_pct = 10;
                default: rx_idle_pct = 40;
            endcase
            repeat ($urandom_range(5, 10))
            begin
                rows = (eff > 48) ? 1 : $urandom_range(1, 6);
                n = (eff > 48) ? $urandom_range(1, 40) : rows * eff;
                if ($urandom_range(0, 4) == 0)
                    n = $urandom_range(1, n);
                side = $urandom_range(0, (rows < eff) ? rows : eff);
                queue_matrix(eff, n,
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
                                                         : $urandom_range(60, 100),
                             side);
                random_cells += n;
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        mismatches += pending_max_sides.size();

        $display("Streamed %0d cells in %0d matrices over %0d row-width writes (0 to 2047).",
                 cells_sent, results_checked, width_writes);
        $display("Input was held off for %0d cycles under result back-pressure.",
                 in_stall_cycles);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/msq_pkg.sv
hdl/msq_cell.sv
hdl/msq_front.sv
hdl/msq_tail.sv
hdl/max_square_of_ones.sv
hdl/msq_checker.sv
tb/max_square_of_ones_test.sv
